// ----- sv/tma_pkg.sv -----
// ----------------------------------------------------------------------------
// Tachometer moving-average package
// Shared widths, codes, types and constants for the tachometer rpm core.
// ----------------------------------------------------------------------------
package tma_pkg;

   localparam int OP_W   = 2;
   localparam int TICK_W = 32;
   localparam int RPM_W  = 30;
   localparam int CSR_W  = 5;

   localparam int MAX_PULSES_DEFAULT = 16;

   // 60e6 microseconds per minute times 16 fractional steps per rpm.
   localparam logic [RPM_W-1:0] RPM_X16_NUMERATOR = 30'd960000000;

   localparam logic [CSR_W-1:0] PULSES_RESET = 5'd1;

   typedef enum logic [OP_W-1:0] {
      OP_FALL    = 2'd0,
      OP_RISE    = 2'd1,
      OP_TIMEOUT = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV_AVG,
      ST_MUL,
      ST_RPM_START,
      ST_DIV_RPM,
      ST_EMIT
   } state_type;

   // Handshake between the sequencer and the shared divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- sv/tma_ram.sv -----
// ----------------------------------------------------------------------------
// Tachometer generic RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tma_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/tma_divider.sv -----
// ----------------------------------------------------------------------------
// Tachometer shared divider
// Restoring radix-2 divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tma_divider
#(
   parameter int DIVIDEND_W = 36,
   parameter int DIVISOR_W  = 37
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_W-1:0]    dividend,
   input  logic [DIVISOR_W-1:0]     divisor,
   output logic [DIVIDEND_W-1:0]    quotient,
   output tma_pkg::div_status_type  status
);
   import tma_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DIVISOR_W:0]    rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W+1:0]  diff;
   logic                  fits;

   always_comb begin
      rem_shift = {rem_ff[DIVISOR_W-1:0], quot_ff[DIVIDEND_W-1]};
      diff      = {1'b0, rem_shift} - {2'b00, dsr_ff};
      fits      = !diff[DIVISOR_W+1];

      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[DIVIDEND_W-2:0], fits};
         rem_in  = fits ? diff[DIVISOR_W:0] : rem_shift;
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign quotient    = quot_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ----- sv/tachometer_moving_average_rpm_core.sv -----
// ----------------------------------------------------------------------------
// Tachometer moving-average rpm core
// Converts timestamped pin events into shaft speed in 1/16 rpm.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one pin event per item: an operation code (falling
//   edge, rising edge or watchdog timeout) and a 32-bit microsecond tick. The
//   rsp channel returns at most one item per event: rpm_x16 and timed_out.
//   The csr channel writes the pulse count (sensor pulses per revolution). The
//   user must write it only while the core is idle; the core does not enforce
//   this itself. It is always ready and takes effect on the next rising edge.
//   Falling edges, the first rising edge and unused codes finish in the
//   accepting cycle and return no item. A timeout passes through the emit
//   state to the output register, which then returns its item. A measuring
//   rising edge reads its window from the period RAM, one entry per cycle;
//   then the single radix-2 divider computes the window average, one multiply
//   rebuilds the divisor, and the divider computes rpm, a pass that is skipped
//   and reported as zero speed when the product is zero.
//   The core handles one event at a time; req_ready is low while an event is
//   in progress. The finished item sits in an output register, so the next
//   event is accepted while an earlier item still waits on a stalled receiver;
//   that event's own item then waits until the output register frees up.
//   Reset is synchronous and clears the measurement and sets the pulse count
//   to one. The period RAM needs no clearing pass: only slots written since
//   the last clear are ever read.
// ----------------------------------------------------------------------------
module tachometer_moving_average_rpm_core
#(
   parameter int MAX_PULSES = tma_pkg::MAX_PULSES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [tma_pkg::OP_W-1:0]    req_operation,
   input  logic [tma_pkg::TICK_W-1:0]  req_tick,

   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [tma_pkg::RPM_W-1:0]   rsp_rpm_x16,
   output logic                        rsp_timed_out,

   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [tma_pkg::CSR_W-1:0]   csr_pulse_count
);
   import tma_pkg::*;

   // Ring index, window count and sum widths all follow from the window depth.
   localparam int IDX_W = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1;
   localparam int CNT_W = $clog2(MAX_PULSES + 1);
   localparam int SUM_W = TICK_W + $clog2(MAX_PULSES);
   localparam int DEN_W = TICK_W + CNT_W;
   localparam int CMP_W = CNT_W + CSR_W;

   // Configuration register.
   logic [CSR_W-1:0]  ppr_ff, ppr_in;

   // Measurement state.
   logic [TICK_W-1:0] last_tick_ff, last_tick_in;
   logic              last_valid_ff, last_valid_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  head_ff, head_in;

   // Sequencer state and working registers.
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [DEN_W-1:0]  denom_ff, denom_in;
   logic [RPM_W-1:0]  res_rpm_ff, res_rpm_in;
   logic              res_to_ff, res_to_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RPM_W-1:0]  rsp_rpm_ff, rsp_rpm_in;
   logic              rsp_to_ff, rsp_to_in;

   // Combinational helpers.
   logic [CMP_W-1:0]  ppr_wide;
   logic [CNT_W-1:0]  n_eff;
   logic              accept;
   logic [TICK_W-1:0] period;
   logic [IDX_W-1:0]  slot_dec;
   logic              wr_en;
   logic [TICK_W-1:0] rd_data;
   logic [DEN_W-1:0]  mul_a, mul_b;

   // Shared divider port.
   logic              div_start;
   logic [SUM_W-1:0]  div_dividend;
   logic [DEN_W-1:0]  div_divisor;
   logic [SUM_W-1:0]  div_quot;
   div_status_type    div_status;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign period    = req_tick - last_tick_ff;

   // A pulse count of zero counts as one, and anything above the window
   // depth is clamped to it, both for the window and the rpm formula.
   always_comb begin
      ppr_wide = CMP_W'(ppr_ff);
      if (ppr_wide == '0) begin
         n_eff = CNT_W'(1);
      end else if (ppr_wide > CMP_W'(MAX_PULSES)) begin
         n_eff = CNT_W'(MAX_PULSES);
      end else begin
         n_eff = ppr_wide[CNT_W-1:0];
      end
   end

   // The window is walked backward from the newest period.
   assign slot_dec = (slot_ff == '0) ? IDX_W'(MAX_PULSES - 1) : slot_ff - IDX_W'(1);

   // The average times the effective pulse count rebuilds the divisor for rpm.
   assign mul_a = DEN_W'(div_quot[TICK_W-1:0]);
   assign mul_b = DEN_W'(n_eff);

   always_comb begin
      ppr_in        = ppr_ff;
      last_tick_in  = last_tick_ff;
      last_valid_in = last_valid_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      state_in      = state_ff;
      n_in          = n_ff;
      issue_in      = issue_ff;
      slot_in       = slot_ff;
      rd_pend_in    = 1'b0;
      sum_in        = sum_ff;
      denom_in      = denom_ff;
      res_rpm_in    = res_rpm_ff;
      res_to_in     = res_to_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_rpm_in    = rsp_rpm_ff;
      rsp_to_in     = rsp_to_ff;
      wr_en         = 1'b0;
      div_start     = 1'b0;
      div_dividend  = sum_ff;
      div_divisor   = DEN_W'(n_ff);

      if (csr_valid && csr_ready) begin
         ppr_in = csr_pulse_count;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_TIMEOUT) begin
                  // A timeout drops the whole measurement and reports zero.
                  last_tick_in  = '0;
                  last_valid_in = 1'b0;
                  count_in      = '0;
                  head_in       = '0;
                  sum_in        = '0;
                  res_rpm_in    = '0;
                  res_to_in     = 1'b1;
                  state_in      = ST_EMIT;
               end else if (req_operation == OP_RISE) begin
                  last_tick_in  = req_tick;
                  last_valid_in = 1'b1;
                  if (last_valid_ff) begin
                     // Store the new period at the head, advance the ring and
                     // then sum the newest min(count, n_eff) entries.
                     wr_en   = 1'b1;
                     head_in = (head_ff == IDX_W'(MAX_PULSES - 1)) ? '0
                                                                   : head_ff + IDX_W'(1);
                     if (count_ff < CNT_W'(MAX_PULSES)) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                     n_in     = (count_in < n_eff) ? count_in : n_eff;
                     slot_in  = head_in;
                     issue_in = '0;
                     sum_in   = '0;
                     state_in = ST_SUM;
                  end
               end
            end
         end

         ST_SUM: begin
            if (rd_pend_ff) begin
               sum_in = sum_ff + SUM_W'(rd_data);
            end
            if (issue_ff < n_ff) begin
               slot_in    = slot_dec;
               issue_in   = issue_ff + CNT_W'(1);
               rd_pend_in = 1'b1;
            end else if (!rd_pend_ff) begin
               div_start    = 1'b1;
               div_dividend = sum_ff;
               div_divisor  = DEN_W'(n_ff);
               state_in     = ST_DIV_AVG;
            end
         end

         ST_DIV_AVG: begin
            if (div_status.done) begin
               state_in = ST_MUL;
            end
         end

         ST_MUL: begin
            denom_in = mul_a * mul_b;
            state_in = ST_RPM_START;
         end

         ST_RPM_START: begin
            // Equal ticks give a zero average, which reports zero speed.
            if (denom_ff == '0) begin
               res_rpm_in = '0;
               res_to_in  = 1'b0;
               state_in   = ST_EMIT;
            end else begin
               div_start    = 1'b1;
               div_dividend = SUM_W'(RPM_X16_NUMERATOR);
               div_divisor  = denom_ff;
               state_in     = ST_DIV_RPM;
            end
         end

         ST_DIV_RPM: begin
            if (div_status.done) begin
               res_rpm_in = div_quot[RPM_W-1:0];
               res_to_in  = 1'b0;
               state_in   = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_rpm_in   = res_rpm_ff;
               rsp_to_in    = res_to_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ppr_ff        <= PULSES_RESET;
         last_tick_ff  <= '0;
         last_valid_ff <= 1'b0;
         count_ff      <= '0;
         head_ff       <= '0;
         state_ff      <= ST_IDLE;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         ppr_ff        <= ppr_in;
         last_tick_ff  <= last_tick_in;
         last_valid_ff <= last_valid_in;
         count_ff      <= count_in;
         head_ff       <= head_in;
         state_ff      <= state_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      n_ff       <= n_in;
      issue_ff   <= issue_in;
      slot_ff    <= slot_in;
      sum_ff     <= sum_in;
      denom_ff   <= denom_in;
      res_rpm_ff <= res_rpm_in;
      res_to_ff  <= res_to_in;
      rsp_rpm_ff <= rsp_rpm_in;
      rsp_to_ff  <= rsp_to_in;
   end

   tma_ram #(
      .WIDTH (TICK_W),
      .DEPTH (MAX_PULSES),
      .ADDR_W(IDX_W)
   ) u_window (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(head_ff),
      .wr_data(period),
      .rd_addr(slot_dec),
      .rd_data(rd_data)
   );

   tma_divider #(
      .DIVIDEND_W(SUM_W),
      .DIVISOR_W (DEN_W)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .quotient(div_quot),
      .status  (div_status)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rpm_x16   = rsp_rpm_ff;
   assign rsp_timed_out = rsp_to_ff;

   // The window never reports more periods than it can hold.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PULSES))
      else $error("window count exceeds depth");

   // Summing always covers at least one stored period and no more than stored.
   a_sum_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> (n_ff != '0) && (n_ff <= count_ff))
      else $error("window span out of range");

   // A timeout leaves an empty measurement behind.
   a_timeout_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == OP_TIMEOUT) |=>
         (!last_valid_ff && count_ff == '0 && head_ff == '0))
      else $error("timeout did not clear the measurement");

   // The divider finishes only while the sequencer waits for it.
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV_AVG || state_ff == ST_DIV_RPM))
      else $error("divider finished outside a division state");

   // A staged result reaches the output register once it is free.
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && (!rsp_valid_ff || rsp_ready)) |=>
         (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("staged result was not delivered");

endmodule

// ----- tb/tachometer_moving_average_rpm_core_test.sv -----
// ----------------------------------------------------------------------------
// Tachometer moving-average rpm core testbench
// Sends pin events and checks every rpm item against a cycle-free predictor.
// The predictor keeps its own copy of the period ring and the pulse count.
// Directed tests cover the corner cases. Random rising-edge trains then run
// under three idling patterns, with the pulse count changed between chunks.
// ----------------------------------------------------------------------------
module tachometer_moving_average_rpm_core_test;

   import tma_pkg::*;

   localparam int MAX_PULSES = MAX_PULSES_DEFAULT;
   localparam int RING_IDX_W = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1;

   // Operation code that the core must ignore.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int RESULT_LATENCY = 120;
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int CHUNK_ITEMS    = 50;

   typedef struct packed {
      logic [RPM_W-1:0] rpm_x16;
      logic             timed_out;
   } speed_item_type;

   logic             clock;
   logic             reset = 1'b1;

   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [OP_W-1:0]  req_operation = OP_FALL;
   logic [TICK_W-1:0] req_tick = '0;

   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [RPM_W-1:0] rsp_rpm_x16;
   logic             rsp_timed_out;

   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_pulse_count = PULSES_RESET;

   // Predictor state.
   logic [CSR_W-1:0]  pulses_shadow = PULSES_RESET;
   logic [TICK_W-1:0] last_rise_tick = '0;
   logic              rise_seen = 1'b0;
   logic [TICK_W-1:0] period_ring [0:MAX_PULSES-1];
   int                ring_fill = 0;
   int                ring_head = 0;

   speed_item_type    expected_speeds [$];
   speed_item_type    oldest_speed;

   int                error_count = 0;
   int                cycle_count = 0;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;

   tachometer_moving_average_rpm_core #(
      .MAX_PULSES (MAX_PULSES)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_tick           (req_tick),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_rpm_x16        (rsp_rpm_x16),
      .rsp_timed_out      (rsp_timed_out),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_pulse_count    (csr_pulse_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run guard: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // The receiver stalls at random, at the rate of the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // Every accepted rsp item is compared with the oldest predicted speed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_speeds.size() == 0) begin
            report_mismatch($sformatf("unexpected item rpm_x16=%0d timed_out=%0b",
                                      rsp_rpm_x16, rsp_timed_out));
         end else begin
            oldest_speed = expected_speeds[0];
            expected_speeds.delete(0);
            if (rsp_rpm_x16 !== oldest_speed.rpm_x16)
               report_mismatch($sformatf("rpm_x16 is %0d, predicted %0d",
                                         rsp_rpm_x16, oldest_speed.rpm_x16));
            if (rsp_timed_out !== oldest_speed.timed_out)
               report_mismatch($sformatf("timed_out is %0b, predicted %0b",
                                         rsp_timed_out, oldest_speed.timed_out));
         end
      end
   end

   // Works out the speed item, if any, that one accepted event causes, and
   // advances the predictor state the way the core does.
   function automatic void predict_speed(input logic [OP_W-1:0] op,
                                         input logic [TICK_W-1:0] tick);
      logic [TICK_W-1:0] period;
      logic [63:0]       window_total;
      logic [63:0]       mean;
      logic [63:0]       denom;
      logic [63:0]       rpm;
      int                pulses;
      int                used;
      int                slot;
      int                i;
      speed_item_type    outcome;

      if (op == OP_TIMEOUT) begin
         // A timeout reports standstill and forgets the whole measurement.
         last_rise_tick = '0;
         rise_seen      = 1'b0;
         ring_fill      = 0;
         ring_head      = 0;
         outcome.rpm_x16   = '0;
         outcome.timed_out = 1'b1;
         expected_speeds = {expected_speeds, outcome};
         return;
      end
      if (op != OP_RISE)
         return;
      if (!rise_seen) begin
         // The first rising edge only starts the period measurement.
         last_rise_tick = tick;
         rise_seen      = 1'b1;
         return;
      end

      if (pulses_shadow == 0)
         pulses = 1;
      else if (pulses_shadow > MAX_PULSES)
         pulses = MAX_PULSES;
      else
         pulses = int'(pulses_shadow);

      period         = tick - last_rise_tick;
      last_rise_tick = tick;
      period_ring[RING_IDX_W'(ring_head)] = period;
      ring_head = (ring_head == MAX_PULSES - 1) ? 0 : ring_head + 1;
      if (ring_fill < MAX_PULSES)
         ring_fill++;

      // During start-up only the periods stored so far are averaged.
      used         = (ring_fill < pulses) ? ring_fill : pulses;
      window_total = '0;
      slot         = ring_head;
      for (i = 0; i < used; i++) begin
         slot = (slot == 0) ? MAX_PULSES - 1 : slot - 1;
         window_total += 64'(period_ring[RING_IDX_W'(slot)]);
      end
      mean  = window_total / used;
      denom = mean * pulses;
      rpm   = (denom == 0) ? 64'd0 : 64'(RPM_X16_NUMERATOR) / denom;

      outcome.rpm_x16   = rpm[RPM_W-1:0];
      outcome.timed_out = 1'b0;
      expected_speeds = {expected_speeds, outcome};
   endfunction

   // Offers one event on the req channel and waits for it to be taken. Valid
   // is left high afterwards, so a following event goes out back to back.
   task automatic send_event(input logic [OP_W-1:0] op, input logic [TICK_W-1:0] tick);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_tick      <= tick;
      do
         @(posedge clock);
      while (!req_ready);
      predict_speed(op, tick);
   endtask

   // Stops the sender and waits until every predicted item has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_speeds.size() != 0)
         @(posedge clock);
      repeat (RESULT_LATENCY) @(posedge clock);
   endtask

   // The core must be idle for a register write, so the pipe is drained first.
   task automatic write_pulse_count(input logic [CSR_W-1:0] value);
      drain_results();
      csr_valid       <= 1'b1;
      csr_pulse_count <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid     <= 1'b0;
      pulses_shadow  = value;
   endtask

   function automatic logic [TICK_W-1:0] pick_period();
      case ($urandom_range(3))
         0:       return $urandom_range(0, 64);
         1:       return $urandom_range(500, 50000);
         2:       return $urandom_range(50000, 5000000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CSR_W-1:0] pick_pulses();
      case ($urandom_range(7))
         0:       return 5'd1;
         1:       return 5'd16;
         2:       return CSR_W'($urandom_range(0, 31));
         default: return CSR_W'($urandom_range(1, 16));
      endcase
   endfunction

   // Mostly regular rising-edge trains with falling edges between them, plus
   // timeouts, stray rising edges and ignored codes as noise.
   task automatic run_traffic(input int target);
      int                counted;
      int                kind;
      logic [TICK_W-1:0] tick;
      logic [TICK_W-1:0] base;
      logic [TICK_W-1:0] period;

      counted = 0;
      tick    = $urandom;
      base    = pick_period();
      while (counted < target) begin
         kind = $urandom_range(99);
         if (kind < 3) begin
            send_event(OP_TIMEOUT, $urandom);
            base = pick_period();
            counted++;
         end else if (kind < 6) begin
            send_event(OP_UNUSED, $urandom);
            counted++;
         end else if (kind < 10) begin
            tick = $urandom;
            send_event(OP_RISE, tick);
            counted++;
         end else begin
            if (kind < 14)
               base = pick_period();
            period = base + $urandom_range(0, 7);
            if ($urandom_range(1) == 1) begin
               send_event(OP_FALL, tick + (period >> 1));
               counted++;
            end
            tick = tick + period;
            send_event(OP_RISE, tick);
            counted++;
         end
      end
   endtask

   // Right after reset the pulse count is one; falling edges and the unused
   // code do nothing, and the first rising edge only records its tick.
   task automatic test_reset_defaults();
      send_event(OP_FALL, 32'h0000_0000);
      send_event(OP_UNUSED, 32'hFFFF_FFFF);
      send_event(OP_RISE, 32'hFFFF_FFF0);
      send_event(OP_RISE, 32'h0000_0010);
   endtask

   // A timeout reports zero with its flag and restarts the measurement. Also
   // the shortest period and equal ticks, which give a zero average.
   task automatic test_timeout_clears();
      send_event(OP_TIMEOUT, 32'h1234_5678);
      send_event(OP_RISE, 32'd100);
      send_event(OP_RISE, 32'd101);
      send_event(OP_RISE, 32'd101);
      send_event(OP_TIMEOUT, 32'h0000_0000);
      send_event(OP_TIMEOUT, 32'hFFFF_FFFF);
   endtask

   // The longest possible period, then a period that wraps past zero.
   task automatic test_tick_extremes();
      send_event(OP_RISE, 32'h0000_0000);
      send_event(OP_RISE, 32'hFFFF_FFFF);
      send_event(OP_RISE, 32'h0000_0000);
   endtask

   // Window start-up at sixteen pulses, then settings out of range and a
   // change of the pulse count on a running measurement.
   task automatic test_pulse_settings();
      write_pulse_count(5'd16);
      send_event(OP_TIMEOUT, 32'h0000_0000);
      send_event(OP_RISE, 32'd1000);
      send_event(OP_RISE, 32'd2000);
      send_event(OP_RISE, 32'd3500);
      write_pulse_count(5'd31);
      send_event(OP_RISE, 32'd4500);
      write_pulse_count(5'd0);
      send_event(OP_RISE, 32'd4600);
      write_pulse_count(5'd17);
      send_event(OP_RISE, 32'd4700);
      write_pulse_count(5'd1);
   endtask

   // Random traffic in chunks, each under a fresh pulse count.
   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int chunks);
      int c;

      for (c = 0; c < chunks; c++) begin
         write_pulse_count(pick_pulses());
         send_idle_pct  = send_pct;
         recv_stall_pct = recv_pct;
         run_traffic(CHUNK_ITEMS);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_timeout_clears();
      test_tick_extremes();
      test_pulse_settings();

      test_random_traffic(15, 56, 5);
      test_random_traffic(56, 15, 5);
      test_random_traffic(0, 0, 5);

      drain_results();
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
